// ----- rtl/ptwci_pkg.sv -----
package ptwci_pkg;

  // Field widths of the sample and result transfers
  localparam int unsigned TIME_BITS     = 10;
  localparam int unsigned SIGNAL_BITS   = 10;
  localparam int unsigned ACC_BITS      = 21;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = ACC_BITS;

  // Divider step counter
  localparam int unsigned DIV_CNT_BITS  = $clog2(ACC_BITS);

  // Register reset values
  localparam logic [TIME_BITS-1:0] WINDOW_HIGH_RST = TIME_BITS'(1023);
  localparam logic [ACC_BITS-1:0]  CLAMP_RST       = ACC_BITS'(1023);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_LOW        = 3'd0,
    CFG_WINDOW_HIGH       = 3'd1,
    CFG_PEAK_MODE         = 3'd2,
    CFG_AVERAGE_MODE      = 3'd3,
    CFG_CLAMP_VALUE       = 3'd4,
    CFG_DISPLAY_THRESHOLD = 3'd5
  } cfg_idx_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] window_low;
    logic [TIME_BITS-1:0] window_high;
    logic                 peak_mode;
    logic                 average_mode;
    logic [ACC_BITS-1:0]  clamp_value;
    logic [ACC_BITS-1:0]  display_threshold;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   time_bin;
    logic [SIGNAL_BITS-1:0] adc_signal;
    logic                   sample_valid;
    logic                   pad_end;
  } in_item_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] pad_result;
    logic                above_threshold;
  } out_item_t;

  // Finished pad handed from front to back
  typedef struct packed {
    logic [ACC_BITS-1:0]  acc;
    logic                 div_en;   // sum mode with averaging
    logic                 win_inv;  // window low above window high
    logic [TIME_BITS-1:0] width;
  } pad_rec_t;

endpackage

// ----- rtl/ptwci_front.sv -----
module ptwci_front import ptwci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     item_valid_i,
  output logic     item_ready_o,
  input  in_item_t item_i,
  output logic     rec_push_o,
  output pad_rec_t rec_o,
  input  logic     rec_full_i
);

  logic [ACC_BITS-1:0]    acc_q, acc_d;
  logic                   accept;
  logic [TIME_BITS-1:0]   width;
  logic                   in_win;
  logic                   half;
  logic [SIGNAL_BITS-1:0] add;
  logic [ACC_BITS:0]      sum;
  logic [ACC_BITS-1:0]    sum_sat;
  logic [ACC_BITS-1:0]    sig_ext;
  logic [ACC_BITS-1:0]    peak_val;
  logic [ACC_BITS-1:0]    acc_upd;

  assign item_ready_o = !rec_full_i;
  assign accept       = item_valid_i && !rec_full_i;

  // Window test and border weighting
  assign width  = cfg_i.window_high - cfg_i.window_low;
  assign in_win = (item_i.time_bin >= cfg_i.window_low) &&
                  (item_i.time_bin <= cfg_i.window_high);
  assign half   = !width[0] && ((item_i.time_bin == cfg_i.window_low) ||
                                (item_i.time_bin == cfg_i.window_high));
  assign add    = half ? (item_i.adc_signal >> 1) : item_i.adc_signal;

  // Saturating sum and running peak
  assign sum      = {1'b0, acc_q} + (ACC_BITS+1)'(add);
  assign sum_sat  = sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
  assign sig_ext  = ACC_BITS'(item_i.adc_signal);
  assign peak_val = (sig_ext > acc_q) ? sig_ext : acc_q;

  always_comb begin
    acc_upd = acc_q;
    if (item_i.sample_valid && in_win) begin
      acc_upd = cfg_i.peak_mode ? peak_val : sum_sat;
    end
  end

  // Pad record towards the back end
  assign rec_push_o    = accept && item_i.pad_end;
  assign rec_o.acc     = acc_upd;
  assign rec_o.div_en  = !cfg_i.peak_mode && cfg_i.average_mode;
  assign rec_o.win_inv = cfg_i.window_high < cfg_i.window_low;
  assign rec_o.width   = width;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = item_i.pad_end ? '0 : acc_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- rtl/ptwci_fifo.sv -----
module ptwci_fifo import ptwci_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pad_rec_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output pad_rec_t rdata_o,
  output logic     empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  pad_rec_t            mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_BITS'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/ptwci_back.sv -----
module ptwci_back import ptwci_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  pad_rec_t  rec_i,
  input  logic      rec_empty_i,
  output logic      rec_pop_o,
  output out_item_t result_o,
  output logic      empty_o,
  input  logic      pop_i
);

  back_state_e             state_q, state_d;
  logic [ACC_BITS-1:0]     quot_q, quot_d;
  logic [TIME_BITS-1:0]    rem_q, rem_d;
  logic [TIME_BITS-1:0]    den_q, den_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  out_item_t               out_q, out_d;
  logic                    out_vld_q, out_vld_d;
  logic                    slot_free;
  logic                    need_div;
  logic [ACC_BITS-1:0]     direct_val;
  logic [TIME_BITS:0]      rem_sh;
  logic [TIME_BITS:0]      rem_diff;
  logic                    qbit;

  // Clamp and threshold compare of a finished value
  function automatic out_item_t finish(input logic [ACC_BITS-1:0] v,
                                       input logic [ACC_BITS-1:0] clamp,
                                       input logic [ACC_BITS-1:0] thr);
    out_item_t r;
    r.pad_result      = (v > clamp) ? clamp : v;
    r.above_threshold = (r.pad_result > thr);
    return r;
  endfunction

  assign empty_o   = !out_vld_q;
  assign result_o  = out_q;
  assign slot_free = !out_vld_q || pop_i;

  // Values that need no division
  assign need_div = rec_i.div_en && !rec_i.win_inv && (rec_i.width != '0);
  always_comb begin
    if (!rec_i.div_en) begin
      direct_val = rec_i.acc;
    end else if (rec_i.win_inv) begin
      direct_val = '0;
    end else begin
      direct_val = cfg_i.clamp_value;
    end
  end

  // Restoring divider step, one quotient bit a cycle
  assign rem_sh   = {rem_q, quot_q[ACC_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign qbit     = (rem_sh >= {1'b0, den_q});

  always_comb begin
    state_d   = state_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    den_d     = den_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    rec_pop_o = 1'b0;
    if (out_vld_q && pop_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      BK_IDLE: begin
        if (!rec_empty_i) begin
          if (need_div) begin
            rec_pop_o = 1'b1;
            quot_d    = rec_i.acc;
            rem_d     = '0;
            den_d     = rec_i.width;
            cnt_d     = DIV_CNT_BITS'(ACC_BITS - 1);
            state_d   = BK_DIV;
          end else if (slot_free) begin
            rec_pop_o = 1'b1;
            out_d     = finish(direct_val, cfg_i.clamp_value, cfg_i.display_threshold);
            out_vld_d = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_d  = qbit ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        quot_d = {quot_q[ACC_BITS-2:0], qbit};
        if (cnt_q == '0) begin
          state_d = BK_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      BK_OUT: begin
        if (slot_free) begin
          out_d     = finish(quot_q, cfg_i.clamp_value, cfg_i.display_threshold);
          out_vld_d = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    out_q  <= out_d;
  end

endmodule

// ----- rtl/pad_time_window_charge_integrator_core.sv -----
// Channel    Handshake              Payload
// ---------  ---------------------  ------------------------------
// samples    push / full            item_i   (in_item_t)
// results    empty / pop            result_o (out_item_t)
// config     cfg_we_i, cfg_idx_i    cfg_wdata_i, no wait states
//
// A sample is taken whenever push is high and full is low.
// An accepted pad end is written into the pad queue. Averaged pads with
// a nonzero, non-inverted window then pass the back-end divider (one
// quotient bit a cycle) and BK_OUT; others go straight to the result register.
// full rises only when the pad queue holds QUEUE_DEPTH finished pads.
// Reset is asynchronous and leaves config registers at their defaults, accumulator 0.
module pad_time_window_charge_integrator_core import ptwci_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  in_item_t                 item_i,
  output logic                     empty,
  input  logic                     pop,
  output out_item_t                result_o
);

  cfg_t     cfg_q;
  pad_rec_t rec_in, rec_out;
  logic     rec_push, rec_pop, rec_full, rec_empty;
  logic     item_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low        <= '0;
      cfg_q.window_high       <= WINDOW_HIGH_RST;
      cfg_q.peak_mode         <= 1'b0;
      cfg_q.average_mode      <= 1'b0;
      cfg_q.clamp_value       <= CLAMP_RST;
      cfg_q.display_threshold <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_LOW:        cfg_q.window_low        <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_WINDOW_HIGH:       cfg_q.window_high       <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_PEAK_MODE:         cfg_q.peak_mode         <= cfg_wdata_i[0];
        CFG_AVERAGE_MODE:      cfg_q.average_mode      <= cfg_wdata_i[0];
        CFG_CLAMP_VALUE:       cfg_q.clamp_value       <= cfg_wdata_i[ACC_BITS-1:0];
        CFG_DISPLAY_THRESHOLD: cfg_q.display_threshold <= cfg_wdata_i[ACC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample intake and accumulation
  ptwci_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (push),
    .item_ready_o (item_ready),
    .item_i       (item_i),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in),
    .rec_full_i   (rec_full)
  );

  assign full = !item_ready;

  // Finished pads between front and back
  ptwci_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rdata_o (rec_out),
    .empty_o (rec_empty)
  );

  // Averaging, clamp and threshold
  ptwci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_i       (rec_out),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // Checks
  a_visible_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.above_threshold) |-> (result_o.pad_result != '0))
    else $error("visible pad with zero result");

  a_rec_push_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> (push && !full && item_i.pad_end))
    else $error("pad record queued without an accepted pad end");

  a_rec_pop_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop |-> !rec_empty)
    else $error("pad record taken from an empty queue");

  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_full |-> !rec_push)
    else $error("pad record queued while queue full");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ptwci_pkg::*;

  localparam int unsigned SETTLE_CYCLES = ACC_BITS + 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1880;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned ITEM_BITS     = $bits(in_item_t);
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  // Tracks register state and running pad value; checks each result transfer
  class pad_result_checker;
    cfg_t                regs;
    logic [ACC_BITS-1:0] acc;
    out_item_t           expected_pads[$];
    int unsigned         errors;

    function new();
      regs             = '0;
      regs.window_high = WINDOW_HIGH_RST;
      regs.clamp_value = CLAMP_RST;
      acc              = '0;
      errors           = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_WINDOW_LOW:        regs.window_low        = data[TIME_BITS-1:0];
        CFG_WINDOW_HIGH:       regs.window_high       = data[TIME_BITS-1:0];
        CFG_PEAK_MODE:         regs.peak_mode         = data[0];
        CFG_AVERAGE_MODE:      regs.average_mode      = data[0];
        CFG_CLAMP_VALUE:       regs.clamp_value       = data[ACC_BITS-1:0];
        CFG_DISPLAY_THRESHOLD: regs.display_threshold = data[ACC_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Fold one accepted item into the pad; a pad end queues the expected result
    function void note_sample(in_item_t it);
      logic [TIME_BITS-1:0]   width;
      logic [SIGNAL_BITS-1:0] add;
      logic [ACC_BITS:0]      sum;
      logic [ACC_BITS-1:0]    v;
      out_item_t              res;
      if (it.sample_valid && it.time_bin >= regs.window_low &&
          it.time_bin <= regs.window_high) begin
        if (regs.peak_mode) begin
          if (ACC_BITS'(it.adc_signal) > acc) acc = ACC_BITS'(it.adc_signal);
        end else begin
          width = regs.window_high - regs.window_low;
          add   = it.adc_signal;
          // even width: border bins count half
          if (!width[0] && (it.time_bin == regs.window_low ||
                            it.time_bin == regs.window_high))
            add = it.adc_signal >> 1;
          sum = acc + add;
          acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_BITS-1:0];
        end
      end
      if (it.pad_end) begin
        v = acc;
        if (!regs.peak_mode && regs.average_mode) begin
          if (regs.window_high < regs.window_low) begin
            v = '0;
          end else begin
            width = regs.window_high - regs.window_low;
            if (width == '0) v = regs.clamp_value;
            else v = acc / width;
          end
        end
        if (v > regs.clamp_value) v = regs.clamp_value;
        res.pad_result      = v;
        res.above_threshold = (v > regs.display_threshold);
        expected_pads.push_back(res);
        acc = '0;
      end
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
    endfunction

    function void check_pad(out_item_t got);
      out_item_t want;
      if (expected_pads.size() == 0) begin
        flag($sformatf("unexpected result %0d/%0b", got.pad_result, got.above_threshold));
        return;
      end
      want = expected_pads.pop_front();
      if (got.pad_result !== want.pad_result)
        flag($sformatf("pad_result: expected %0d, got %0d", want.pad_result, got.pad_result));
      if (got.above_threshold !== want.above_threshold)
        flag($sformatf("above_threshold: expected %0b, got %0b",
                       want.above_threshold, got.above_threshold));
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;
  logic                     push        = 1'b0;
  logic                     pop         = 1'b0;
  in_item_t                 item_i      = '0;
  logic                     full;
  logic                     empty;
  out_item_t                result_o;

  pad_result_checker board = new();

  int unsigned idle_pct     = 6;
  int unsigned stall_pct    = 6;
  int unsigned quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pad_time_window_charge_integrator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  // Monitor both channels, drive pop, watch for a hung block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_sample(item_i);
      if (pop && !empty) board.check_pad(result_o);
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
    pop <= ($urandom_range(99) >= stall_pct);
  end

  function automatic in_item_t sample_of(logic [TIME_BITS-1:0] t,
                                         logic [SIGNAL_BITS-1:0] sig,
                                         logic valid, logic last);
    in_item_t it;
    it.time_bin     = t;
    it.adc_signal   = sig;
    it.sample_valid = valid;
    it.pad_end      = last;
    return it;
  endfunction

  // Sample aimed at the window borders, just outside them, its inside or anywhere
  function automatic in_item_t make_sample(cfg_t c, logic last);
    in_item_t it;
    case ($urandom_range(5))
      0: it.time_bin = c.window_low;
      1: it.time_bin = c.window_high;
      2: it.time_bin = c.window_low - 1'b1;
      3: it.time_bin = c.window_high + 1'b1;
      4: it.time_bin = TIME_BITS'($urandom_range(c.window_low, c.window_high));
      default: it.time_bin = TIME_BITS'($urandom);
    endcase
    case ($urandom_range(9))
      0: it.adc_signal = '0;
      1: it.adc_signal = '1;
      default: it.adc_signal = SIGNAL_BITS'($urandom);
    endcase
    it.sample_valid = ($urandom_range(99) >= 8);
    it.pad_end      = last;
    return it;
  endfunction

  function automatic cfg_t rand_setting();
    cfg_t                 c;
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
    a = TIME_BITS'($urandom);
    b = TIME_BITS'($urandom);
    case ($urandom_range(5))
      0: begin c.window_low = '0; c.window_high = '1; end
      1: begin
        c.window_low  = a;
        c.window_high = a + TIME_BITS'(2 * $urandom_range(1, 8));
      end
      2: begin c.window_low = a; c.window_high = a; end
      3: begin
        c.window_high = TIME_BITS'($urandom_range(0, 511));
        c.window_low  = c.window_high + TIME_BITS'($urandom_range(1, 512));
      end
      4: begin
        c.window_low  = (a < b) ? a : b;
        c.window_high = (a < b) ? b : a;
      end
      default: begin
        c.window_low  = a;
        c.window_high = a + TIME_BITS'(2 * $urandom_range(0, 8) + 1);
      end
    endcase
    c.peak_mode    = 1'($urandom_range(1));
    c.average_mode = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: c.clamp_value = '0;
      1: c.clamp_value = '1;
      2: c.clamp_value = ACC_BITS'(1023);
      3: c.clamp_value = ACC_BITS'($urandom_range(0, 4095));
      default: c.clamp_value = ACC_BITS'($urandom_range(0, 2097151));
    endcase
    case ($urandom_range(3))
      0: c.display_threshold = '0;
      1: c.display_threshold = '1;
      2: c.display_threshold = ACC_BITS'($urandom_range(0, 2047));
      default: c.display_threshold = ACC_BITS'($urandom_range(0, 2097151));
    endcase
    return c;
  endfunction

  // One sample transfer; push stays high between back-to-back items
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  // Drain all pads, then give the back end time to go idle
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk_i); while (board.expected_pads.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Narrow registers get junk in the unused upper bits
  task automatic set_config(cfg_t c);
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'($urandom);
    data[TIME_BITS-1:0] = c.window_low;
    program_reg(CFG_WINDOW_LOW, data);
    data = CFG_DATA_BITS'($urandom);
    data[TIME_BITS-1:0] = c.window_high;
    program_reg(CFG_WINDOW_HIGH, data);
    data = CFG_DATA_BITS'($urandom);
    data[0] = c.peak_mode;
    program_reg(CFG_PEAK_MODE, data);
    data = CFG_DATA_BITS'($urandom);
    data[0] = c.average_mode;
    program_reg(CFG_AVERAGE_MODE, data);
    program_reg(CFG_CLAMP_VALUE, c.clamp_value);
    program_reg(CFG_DISPLAY_THRESHOLD, c.display_threshold);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    cfg_t        setting;
    int unsigned n;
    int unsigned random_items;
    int unsigned phase;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: empty pad, then a sum over the clamp
    send_item(sample_of(10'd0, 10'd0, 1'b0, 1'b1));
    send_item(sample_of(10'd0, 10'd1023, 1'b1, 1'b0));
    send_item(sample_of(10'd1023, 10'd1023, 1'b1, 1'b0));
    send_item(sample_of(10'd512, 10'd0, 1'b1, 1'b1));

    // Even width: half weight on the borders, outside bins dropped
    settle();
    setting = '{window_low: 10'd100, window_high: 10'd104, peak_mode: 1'b0,
                average_mode: 1'b0, clamp_value: '1, display_threshold: 21'd14};
    set_config(setting);
    send_item(sample_of(10'd100, 10'd7, 1'b1, 1'b0));
    send_item(sample_of(10'd102, 10'd10, 1'b1, 1'b0));
    send_item(sample_of(10'd104, 10'd5, 1'b1, 1'b0));
    send_item(sample_of(10'd99, 10'd1000, 1'b1, 1'b0));
    send_item(sample_of(10'd105, 10'd1000, 1'b1, 1'b0));
    send_item(sample_of(10'd0, 10'd0, 1'b0, 1'b1));
    // Pad left open across a switch to peak mode
    send_item(sample_of(10'd101, 10'd20, 1'b1, 1'b0));
    send_item(sample_of(10'd103, 10'd30, 1'b1, 1'b0));
    settle();
    setting.peak_mode         = 1'b1;
    setting.display_threshold = 21'd50;
    set_config(setting);
    send_item(sample_of(10'd102, 10'd40, 1'b1, 1'b1));

    // Averaging over an even width
    settle();
    setting.peak_mode    = 1'b0;
    setting.average_mode = 1'b1;
    set_config(setting);
    send_item(sample_of(10'd100, 10'd9, 1'b1, 1'b0));
    send_item(sample_of(10'd101, 10'd10, 1'b1, 1'b0));
    send_item(sample_of(10'd104, 10'd1023, 1'b1, 1'b1));

    // Zero width with averaging saturates to the clamp
    settle();
    setting = '{window_low: 10'd300, window_high: 10'd300, peak_mode: 1'b0,
                average_mode: 1'b1, clamp_value: 21'd777, display_threshold: 21'd776};
    set_config(setting);
    send_item(sample_of(10'd300, 10'd5, 1'b1, 1'b1));

    // Inverted window accepts nothing
    settle();
    setting.window_low  = 10'd600;
    setting.window_high = 10'd200;
    set_config(setting);
    send_item(sample_of(10'd400, 10'd1023, 1'b1, 1'b0));
    send_item(sample_of(10'd600, 10'd1023, 1'b1, 1'b1));

    // Zero clamp, top threshold
    settle();
    setting = '{window_low: 10'd0, window_high: 10'd1023, peak_mode: 1'b0,
                average_mode: 1'b0, clamp_value: '0, display_threshold: '1};
    set_config(setting);
    send_item(sample_of(10'd5, 10'd1023, 1'b1, 1'b1));

    // Random settings, mostly well-formed pads with some noise
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      idle_pct  = (phase >= 8 && phase < 14) ? 0 : 6;
      stall_pct = idle_pct;
      setting   = rand_setting();
      set_config(setting);
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(99) < 85) begin
          n = $urandom_range(0, 8);
          if (n == 0) begin
            send_item(sample_of(TIME_BITS'($urandom), SIGNAL_BITS'($urandom), 1'b0, 1'b1));
            random_items++;
          end else begin
            for (int i = 0; i < n; i++) send_item(make_sample(setting, i == n - 1));
            random_items += n;
          end
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_item(in_item_t'(ITEM_BITS'($urandom)));
          random_items += n;
        end
      end
      // Sometimes carry an open pad into the next setting
      if ($urandom_range(99) < 15) begin
        send_item(make_sample(setting, 1'b0));
        send_item(make_sample(setting, 1'b0));
        random_items += 2;
      end
      phase++;
    end
    send_item(sample_of(TIME_BITS'($urandom), SIGNAL_BITS'($urandom), 1'b0, 1'b1));
    settle();

    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
